// ===== src/grid_node_plane_collision_top_assert.svh =====
// assertion macros shared by the checker
`ifndef GRID_NODE_PLANE_COLLISION_TOP_ASSERT_SVH
`define GRID_NODE_PLANE_COLLISION_TOP_ASSERT_SVH
`define GNPC_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define GNPC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// ===== src/gnpc_pkg.sv =====
// shared types and constants for the grid node plane collision block
package gnpc_pkg;
  localparam int unsigned InWidth  = 248;
  localparam int unsigned OutWidth = 88;
  // flat node index space for the position; indexes wrap modulo this
  localparam int unsigned MaxNodes = 65536;
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_CELL     = 3'd2;
  localparam logic [2:0] REG_ROW      = 3'd3;
  localparam logic [2:0] REG_COUNT    = 3'd4;

  // datapath commands
  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_DIV, OP_POS, OP_PLANE_RD, OP_DIST_A, OP_DIST_B,
    OP_VN_A, OP_VN_B, OP_CORR_X, OP_CORR_Y, OP_APPLY
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] plane;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic skip;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // add half lsb then floor shift by 16
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd32768;
    return t >>> 16;
  endfunction
endpackage

// ===== src/gnpc_ctrl.sv =====
// controller sequencing the divide, position and per plane steps
module gnpc_ctrl #(
  parameter int unsigned PLANES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             node_item,
  input  logic [2:0]       plane_count,
  input  gnpc_pkg::sts_t   sts,
  input  logic             out_free,
  output gnpc_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);
  import gnpc_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_POS, S_RD, S_DA, S_DB, S_VA, S_VB, S_CX, S_CY, S_AP, S_OUT
  } state_t;
  localparam int unsigned PW = $clog2(PLANES + 1);
  state_t st_r;
  logic [3:0] pl_r;
  logic [PW-1:0] cnt;
  logic last;

  // effective plane count clamped to table size
  assign cnt  = ({1'b0, plane_count} > 4'(PLANES)) ? PW'(PLANES) : PW'(plane_count);
  assign last = ({1'b0, pl_r} + 5'd1) >= 5'(cnt);
  assign busy = (st_r != S_IDLE);
  assign done = (st_r == S_OUT) && out_free;

  always_comb begin
    cmd.plane = pl_r;
    unique case (st_r)
      S_IDLE:  cmd.op = (in_fire && node_item) ? OP_LOAD : OP_IDLE;
      S_DIV:   cmd.op = OP_DIV;
      S_POS:   cmd.op = OP_POS;
      S_RD:    cmd.op = OP_PLANE_RD;
      S_DA:    cmd.op = OP_DIST_A;
      S_DB:    cmd.op = OP_DIST_B;
      S_VA:    cmd.op = OP_VN_A;
      S_VB:    cmd.op = OP_VN_B;
      S_CX:    cmd.op = OP_CORR_X;
      S_CY:    cmd.op = OP_CORR_Y;
      S_AP:    cmd.op = OP_APPLY;
      default: cmd.op = OP_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pl_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_fire && node_item) st_r <= S_DIV;
        S_DIV:  if (sts.div_done) st_r <= S_POS;
        S_POS: begin
          pl_r <= '0;
          st_r <= (cnt == '0) ? S_OUT : S_RD;
        end
        S_RD: st_r <= S_DA;
        S_DA: st_r <= S_DB;
        S_VB, S_DB: begin
          if (sts.skip) begin
            pl_r <= pl_r + 4'd1;
            st_r <= last ? S_OUT : S_RD;
          end else begin
            st_r <= (st_r == S_DB) ? S_VA : S_CX;
          end
        end
        S_VA: st_r <= S_VB;
        S_CX: st_r <= S_CY;
        S_CY: st_r <= S_AP;
        S_AP: begin
          pl_r <= pl_r + 4'd1;
          st_r <= last ? S_OUT : S_RD;
        end
        S_OUT: if (out_free) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/gnpc_dp.sv =====
// datapath: plane table, restoring divider, shared multiplier and momentum update
module gnpc_dp #(
  parameter int unsigned PLANES = 4
) (
  input  logic                        clk,
  input  gnpc_pkg::cmd_t              cmd,
  output gnpc_pkg::sts_t              sts,
  input  logic                        tbl_we,
  input  logic [1:0]                  tbl_slot,
  input  logic [gnpc_pkg::InWidth-1:0] in_data,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic [30:0]                 cell_size,
  input  logic [16:0]                 nodes_per_row,
  output logic signed [31:0]          res_mx,
  output logic signed [31:0]          res_my,
  output logic                        res_acted
);
  import gnpc_pkg::*;
  localparam int unsigned SW = (PLANES > 1) ? $clog2(PLANES) : 1;

  logic signed [17:0] t_nx [PLANES];
  logic signed [17:0] t_ny [PLANES];
  logic signed [31:0] t_ax [PLANES];
  logic signed [31:0] t_ay [PLANES];
  logic signed [31:0] t_fl [PLANES];
  logic               t_st [PLANES];

  logic [15:0] quo_r;
  logic [16:0] rem_r;
  logic [4:0]  dcnt_r;
  logic        mass_r;
  logic signed [31:0] px_r, py_r, mx_r, my_r;
  logic signed [17:0] nx_r, ny_r;
  logic signed [31:0] ax_r, ay_r, fl_r;
  logic        st_r, below_r, acted_r;
  logic signed [65:0] acc_r, vn_r, cx_r;
  logic signed [65:0] prod;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic [16:0] row, trial;
  logic [SW-1:0] rsel, wsel;
  logic signed [31:0] nmx, nmy;

  assign row   = (nodes_per_row == '0) ? 17'd1 : nodes_per_row;
  assign trial = {rem_r[15:0], quo_r[15]};
  assign rsel  = cmd.plane[SW-1:0];
  assign wsel  = SW'(tbl_slot);

  // plane table write
  always_ff @(posedge clk) begin
    if (tbl_we && (32'(tbl_slot) < PLANES)) begin
      t_nx[wsel] <= in_data[20:3];
      t_ny[wsel] <= in_data[38:21];
      t_ax[wsel] <= in_data[70:39];
      t_ay[wsel] <= in_data[102:71];
      t_fl[wsel] <= in_data[134:103];
      t_st[wsel] <= in_data[135];
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_DIST_A: begin mul_a = 34'(nx_r); mul_b = 34'(px_r) - 34'(ax_r); end
      OP_DIST_B: begin mul_a = 34'(ny_r); mul_b = 34'(py_r) - 34'(ay_r); end
      OP_VN_A:   begin mul_a = 34'(nx_r); mul_b = 34'(mx_r); end
      OP_VN_B:   begin mul_a = 34'(ny_r); mul_b = 34'(my_r); end
      OP_CORR_X: begin mul_a = vn_r[33:0]; mul_b = 34'(nx_r); end
      OP_CORR_Y: begin mul_a = vn_r[33:0]; mul_b = 34'(ny_r); end
      default: ;
    endcase
    prod = 66'(mul_a) * 66'(mul_b);
  end

  assign nmx = sat32(66'(mx_r) - rnd16(cx_r));
  assign nmy = sat32(66'(my_r) - rnd16(prod));

  // skip decision after distance or normal component
  always_comb begin
    sts.div_done = (dcnt_r == 5'd16);
    sts.skip = 1'b0;
    unique case (cmd.op)
      OP_DIST_B: sts.skip = below_r || ((acc_r + prod) > 0) ||
                            (!st_r && !mass_r);
      OP_VN_B:   sts.skip = !st_r && ((acc_r + prod) > 0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        quo_r   <= in_data[151:136];
        rem_r   <= '0;
        dcnt_r  <= '0;
        mass_r  <= (in_data[183:152] != '0);
        mx_r    <= in_data[215:184];
        my_r    <= in_data[247:216];
        acted_r <= 1'b0;
      end
      OP_DIV: if (dcnt_r != 5'd16) begin
        // one quotient bit per cycle
        dcnt_r <= dcnt_r + 5'd1;
        if (trial >= row) begin
          rem_r <= trial - row;
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[14:0], 1'b0};
        end
      end
      OP_POS: begin
        px_r <= sat32(66'(origin_x) + 66'({1'b0, cell_size} * {1'b0, rem_r[15:0]}));
        py_r <= sat32(66'(origin_y) + 66'({1'b0, cell_size} * {1'b0, quo_r}));
      end
      OP_PLANE_RD: begin
        nx_r <= t_nx[rsel];
        ny_r <= t_ny[rsel];
        ax_r <= t_ax[rsel];
        ay_r <= t_ay[rsel];
        fl_r <= t_fl[rsel];
        st_r <= t_st[rsel];
      end
      OP_DIST_A: begin
        acc_r   <= prod;
        below_r <= (py_r < fl_r);
      end
      OP_DIST_B: if (st_r) begin
        vn_r <= '0;
        cx_r <= '0;
      end
      OP_VN_A: acc_r <= prod;
      OP_VN_B: vn_r <= rnd16(acc_r + prod);
      OP_CORR_X: cx_r <= prod;
      OP_CORR_Y: begin
        if (st_r) begin
          if (mx_r != '0 || my_r != '0) acted_r <= 1'b1;
          mx_r <= '0;
          my_r <= '0;
        end else begin
          if (nmx != mx_r || nmy != my_r) acted_r <= 1'b1;
          mx_r <= nmx;
          my_r <= nmy;
        end
      end
      default: ;
    endcase
  end

  assign res_mx    = mx_r;
  assign res_my    = my_r;
  assign res_acted = acted_r;
endmodule

// ===== src/grid_node_plane_collision_top.sv =====
// top level of the grid node plane collision block
// Usage: configure origin, cell size, row length and plane count through the
// cfg_ write port while the block is idle. Requests arrive on in_: in_tuser
// is the action; action 0 writes one plane slot and gives no result, action 1
// is one grid node and gives one result on out_.
// A node passes from its accepting edge to out_tvalid through the bit-serial
// row divider, the position step and the step that presents the result, and
// per plane in use through 8 steps around the one shared multiplier (3 when
// the plane is skipped on distance, floor or zero mass, 5 when skipped on the
// normal component). The next request is taken once the result is taken and
// out_valid_r has cleared. Plane writes can follow back to back. One node is
// in work at a time. The result waits in out_ registers until taken;
// in_tready stays low while a node is in work or its result is still held,
// so a stalled receiver stalls the input side. Synchronous reset clears the
// control state and out_tvalid and sets the configuration registers to their
// defaults; plane table contents are undefined until written.
module grid_node_plane_collision_top #(
  parameter int unsigned PLANES    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // action
  input  logic                          in_tuser,
  // plane_slot, normal_x, normal_y, anchor_x, anchor_y, floor_height,
  // sticking, node_index, node_mass, momentum_x, momentum_y
  input  logic [gnpc_pkg::InWidth-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_node_index, new_momentum_x, new_momentum_y, plane_acted
  output logic [gnpc_pkg::OutWidth-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import gnpc_pkg::*;
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [30:0] cell_size_r;
  logic [16:0] nodes_per_row_r;
  logic [2:0]  plane_count_r;
  logic in_fire, busy, done, out_valid_r, res_acted;
  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] res_mx, res_my;
  logic [OutWidth-1:0] out_data_r;
  logic [15:0] idx_wrap;

  // index wraps to the grid size for the position
  assign idx_wrap = (MaxNodes >= 65536) ? in_tdata[150:135] :
                    (in_tdata[150:135] & 16'(MaxNodes - 1));

  assign in_tready = !busy && !out_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cell_size_r <= 31'd65536;
      nodes_per_row_r <= 17'd256;
      plane_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_data;
        REG_ORIGIN_Y: origin_y_r <= cfg_data;
        REG_CELL:     cell_size_r <= cfg_data[30:0];
        REG_ROW:      nodes_per_row_r <= cfg_data[16:0];
        REG_COUNT:    plane_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  gnpc_ctrl #(.PLANES(PLANES)) u_ctrl (
    .clk, .rst_n, .in_fire, .node_item(in_tuser), .plane_count(plane_count_r),
    .sts, .out_free(!out_valid_r), .cmd, .busy, .done
  );

  gnpc_dp #(.PLANES(PLANES)) u_dp (
    .clk, .cmd, .sts,
    .tbl_we(in_fire && !in_tuser), .tbl_slot(in_tdata[1:0]),
    .in_data({in_tdata[246:151], idx_wrap, in_tdata[134:0], in_tuser}),
    .origin_x(origin_x_r), .origin_y(origin_y_r), .cell_size(cell_size_r),
    .nodes_per_row(nodes_per_row_r),
    .res_mx, .res_my, .res_acted
  );

  // output register; echo the unwrapped index
  logic [15:0] echo_r;
  always_ff @(posedge clk) begin
    if (in_fire) echo_r <= in_tdata[150:135];
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {7'd0, res_acted, res_my, res_mx, echo_r};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

// ===== src/gnpc_checker.sv =====
// port level checker for the grid node plane collision block
`include "grid_node_plane_collision_top_assert.svh"
module gnpc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [87:0] out_tdata
);
  `GNPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `GNPC_ASSERT_IMPL(a_no_take_while_full, out_tvalid, !in_tready)
  `GNPC_ASSERT_NEXT(a_node_busy, in_tvalid && in_tready, !out_tvalid)
  `GNPC_ASSERT_IMPL(a_pad_zero, out_tvalid, out_tdata[87:81] == 7'd0)
endmodule

bind grid_node_plane_collision_top gnpc_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

// ===== verif/grid_node_plane_collision_top_tb.sv =====
// self-checking testbench for the grid node plane collision block
`timescale 1ns / 100ps

module grid_node_plane_collision_top_tb;
  import gnpc_pkg::*;

  // one request on the input channel
  typedef struct {
    bit                 action;
    bit [1:0]           slot;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] fl;
    bit                 stick;
    bit [15:0]          idx;
    bit [31:0]          mass;
    logic signed [31:0] mx;
    logic signed [31:0] my;
  } req_t;

  // one node response
  typedef struct packed {
    bit [15:0] idx;
    bit [31:0] mx;
    bit [31:0] my;
    bit        acted;
  } node_res_t;

  // directed row: a request, or a register write
  typedef struct {
    bit        is_cfg;
    logic [2:0] reg_idx;
    bit [31:0] reg_val;
    req_t      req;
    bit        typed;
    node_res_t res;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic                  in_tuser;
  logic [InWidth-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OutWidth-1:0]   out_tdata;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [31:0]           cfg_data;

  grid_node_plane_collision_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the registers and the plane table
  longint cur_ox, cur_oy, cur_cell, cur_row, cur_cnt;
  longint tbl_nx[4], tbl_ny[4], tbl_ax[4], tbl_ay[4], tbl_fl[4];
  bit     tbl_stick[4];

  node_res_t pending_nodes[$];
  int        mismatches;
  int        nodes_seen;
  int        writes_sent;
  int        idle_pct_in, idle_pct_out;
  bit        long_hold;
  row_t      rows[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard limit on run length
  initial begin
    #20000000;
    $display("[grid_node_plane_collision_top] ERROR");
    $finish;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // add half lsb then floor shift by 16
  function automatic longint half_up16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  // expected response of one node against the planes in use
  function automatic node_res_t collide(req_t r);
    node_res_t o;
    longint row, px, py, mx, my, d, vn, nmx, nmy, cnt;
    bit acted;
    acted = 1'b0;
    row = (cur_row == 0) ? 1 : cur_row;
    px = clip32(cur_ox + cur_cell * (longint'(r.idx) % row));
    py = clip32(cur_oy + cur_cell * (longint'(r.idx) / row));
    mx = r.mx;
    my = r.my;
    cnt = (cur_cnt > 4) ? 4 : cur_cnt;
    for (int i = 0; i < cnt; i++) begin
      if (py < tbl_fl[i]) continue;
      d = tbl_nx[i] * (px - tbl_ax[i]) + tbl_ny[i] * (py - tbl_ay[i]);
      if (d > 0) continue;
      if (tbl_stick[i]) begin
        nmx = 0;
        nmy = 0;
      end else begin
        if (r.mass == 0) continue;
        vn = tbl_nx[i] * mx + tbl_ny[i] * my;
        if (vn > 0) continue;
        vn = half_up16(vn);
        nmx = clip32(mx - half_up16(vn * tbl_nx[i]));
        nmy = clip32(my - half_up16(vn * tbl_ny[i]));
      end
      if (nmx != mx || nmy != my) acted = 1'b1;
      mx = nmx;
      my = nmy;
    end
    o.idx = r.idx;
    o.mx = mx[31:0];
    o.my = my[31:0];
    o.acted = acted;
    return o;
  endfunction

  function automatic logic [InWidth-1:0] pack_req(req_t r);
    logic [InWidth-1:0] v;
    v = '0;
    v[246:0] = {r.my, r.mx, r.mass, r.idx, r.stick, r.fl, r.ay, r.ax, r.ny, r.nx,
                r.slot};
    return v;
  endfunction

  // wait until idle, then write one register
  task automatic write_reg(logic [2:0] ri, bit [31:0] val);
    in_tvalid <= 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ri)
      REG_ORIGIN_X: cur_ox = longint'(signed'(val));
      REG_ORIGIN_Y: cur_oy = longint'(signed'(val));
      REG_CELL:     cur_cell = val & 32'h7fffffff;
      REG_ROW:      cur_row = val & 32'h1ffff;
      REG_COUNT:    cur_cnt = val & 32'h7;
      default: ;
    endcase
  endtask

  // offer one request, record its effect once taken
  task automatic send_req(req_t r, bit typed, node_res_t res);
    in_tvalid <= 1'b1;
    in_tuser <= r.action;
    in_tdata <= pack_req(r);
    do @(posedge clk); while (!in_tready);
    if (r.action == 1'b0) begin
      tbl_nx[r.slot] = r.nx;
      tbl_ny[r.slot] = r.ny;
      tbl_ax[r.slot] = r.ax;
      tbl_ay[r.slot] = r.ay;
      tbl_fl[r.slot] = r.fl;
      tbl_stick[r.slot] = r.stick;
      writes_sent++;
    end else begin
      pending_nodes.push_back(typed ? res : collide(r));
    end
    // sender gaps
    if ($urandom_range(99) < idle_pct_in) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct_in);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= !long_hold && !($urandom_range(99) < idle_pct_out);
  end

  // response checker
  always @(posedge clk) begin
    node_res_t want;
    node_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.idx = out_tdata[15:0];
      got.mx = out_tdata[47:16];
      got.my = out_tdata[79:48];
      got.acted = out_tdata[80];
      if (pending_nodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response idx %0d", got.idx);
      end else begin
        want = pending_nodes.pop_front();
        nodes_seen++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d mx %h my %h acted %0d, got %0d %h %h %0d",
                     want.idx, want.mx, want.my, want.acted,
                     got.idx, got.mx, got.my, got.acted);
        end
      end
    end
  end

  function automatic req_t node_req(bit [15:0] i, bit [31:0] m, bit [31:0] x,
                                    bit [31:0] y);
    req_t r;
    r = '{default: 0};
    r.action = 1'b1;
    r.idx = i;
    r.mass = m;
    r.mx = x;
    r.my = y;
    return r;
  endfunction

  function automatic req_t plane_req(bit [1:0] s, bit [17:0] nx, bit [17:0] ny,
                                     bit [31:0] ax, bit [31:0] ay, bit [31:0] fl,
                                     bit st);
    req_t r;
    r = '{default: 0};
    r.slot = s;
    r.nx = nx;
    r.ny = ny;
    r.ax = ax;
    r.ay = ay;
    r.fl = fl;
    r.stick = st;
    return r;
  endfunction

  function automatic void add_req(req_t r, bit typed, node_res_t res);
    row_t w;
    w = '{default: 0};
    w.req = r;
    w.typed = typed;
    w.res = res;
    rows.push_back(w);
  endfunction

  function automatic void add_cfg(logic [2:0] ri, bit [31:0] val);
    row_t w;
    w = '{default: 0};
    w.is_cfg = 1'b1;
    w.reg_idx = ri;
    w.reg_val = val;
    rows.push_back(w);
  endfunction

  function automatic node_res_t res(bit [15:0] i, bit [31:0] x, bit [31:0] y, bit a);
    node_res_t o;
    o.idx = i;
    o.mx = x;
    o.my = y;
    o.acted = a;
    return o;
  endfunction

  // random request with content aimed at the current grid
  function automatic req_t rand_req();
    req_t r;
    longint row, cx, cy;
    int k;
    row = (cur_row == 0) ? 1 : cur_row;
    r = node_req(0, 0, 0, 0);
    if ($urandom_range(99) < 15) begin
      r.action = 1'b0;
      r.slot = 2'($urandom_range(3));
      k = int'($urandom_range(9));
      case (k)
        0: begin r.nx = 18'sd65536;  r.ny = 18'sd0; end
        1: begin r.nx = -18'sd65536; r.ny = 18'sd0; end
        2: begin r.nx = 18'sd0;      r.ny = 18'sd65536; end
        3: begin r.nx = 18'sd0;      r.ny = -18'sd65536; end
        4: begin r.nx = 18'sd46341;  r.ny = 18'sd46341; end
        5: begin r.nx = -18'sd46341; r.ny = 18'sd46341; end
        6: begin r.nx = 18'sd46341;  r.ny = -18'sd46341; end
        default: begin r.nx = 18'($urandom); r.ny = 18'($urandom); end
      endcase
      cx = clip32(cur_ox + cur_cell * longint'($urandom_range(32'(row))));
      cy = clip32(cur_oy + cur_cell * longint'($urandom_range(16)));
      r.ax = ($urandom_range(9) == 0) ? $urandom : 32'(cx);
      r.ay = ($urandom_range(9) == 0) ? $urandom : 32'(cy);
      r.fl = ($urandom_range(3) == 0) ? 32'h80000000 :
             ($urandom_range(9) == 0) ? $urandom :
             32'(clip32(cur_oy + cur_cell * longint'($urandom_range(16))));
      r.stick = ($urandom_range(3) == 0);
    end else begin
      r.idx = ($urandom_range(4) == 0) ? 16'($urandom) :
              16'($urandom_range(32'(row * 16)));
      r.mass = ($urandom_range(5) == 0) ? 32'd0 : $urandom;
      r.mx = ($urandom_range(3) == 0) ? $urandom :
             $urandom_range(2000000) - 32'd1000000;
      r.my = ($urandom_range(3) == 0) ? $urandom :
             $urandom_range(2000000) - 32'd1000000;
    end
    return r;
  endfunction

  initial begin
    node_res_t none;
    req_t      r;
    int        total;
    none = '{default: 0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    long_hold = 1'b0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    mismatches = 0;
    nodes_seen = 0;
    writes_sent = 0;
    cur_ox = 0;
    cur_oy = 0;
    cur_cell = 65536;
    cur_row = 256;
    cur_cnt = 0;
    for (int i = 0; i < 4; i++) begin
      tbl_nx[i] = 0; tbl_ny[i] = 0; tbl_ax[i] = 0;
      tbl_ay[i] = 0; tbl_fl[i] = 0; tbl_stick[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no planes after reset, momentum passes through
    add_req(node_req(0, 1, 32'h7fffffff, 32'h80000000), 1,
            res(0, 32'h7fffffff, 32'h80000000, 0));
    add_req(node_req(16'hffff, 32'hffffffff, 32'hffffffff, 1), 1,
            res(16'hffff, 32'hffffffff, 1, 0));
    // fill every slot, slot 0 sticking over the whole grid
    add_req(plane_req(0, 65536, 0, 32'h7fffffff, 0, 32'h80000000, 1), 0, none);
    add_req(plane_req(1, 0, 65536, 0, 32'h00040000, 32'h80000000, 0), 0, none);
    add_req(plane_req(2, 18'h1ffff, 18'h20000, 32'h80000000, 32'h7fffffff,
                      32'h7fffffff, 0), 0, none);
    add_req(plane_req(3, 18'h20000, 18'h1ffff, 0, 0, 0, 0), 0, none);
    add_cfg(REG_COUNT, 1);
    // sticking zeroes momentum, also at zero mass
    add_req(node_req(5, 0, 5, 7), 1, res(5, 0, 0, 1));
    add_req(node_req(300, 9, 0, 0), 1, res(300, 0, 0, 0));
    // sliding floor plane, then the extreme normals
    add_req(plane_req(0, 0, 65536, 0, 32'h00040000, 32'h80000000, 0), 0, none);
    add_req(node_req(2, 65536, 32'h00010000, 32'hfffe0000), 0, none);
    add_req(node_req(2, 0, 32'h00010000, 32'hfffe0000), 0, none);
    add_cfg(REG_COUNT, 7);
    add_req(node_req(1000, 1, 32'h80000000, 32'h80000000), 0, none);
    add_req(node_req(7, 1, 32'h7fffffff, 32'h7fffffff), 0, none);
    // zero row length and zero cell size, extreme origin
    add_cfg(REG_ROW, 0);
    add_cfg(REG_CELL, 0);
    add_cfg(REG_ORIGIN_X, 32'h80000000);
    add_cfg(REG_ORIGIN_Y, 32'h7fffffff);
    add_req(node_req(16'hffff, 1, 32'hfff00000, 32'h00100000), 0, none);
    add_cfg(REG_CELL, 32'h7fffffff);
    add_cfg(REG_ROW, 32'h10000);
    add_req(node_req(16'hffff, 1, 32'h00100000, 32'hfff00000), 0, none);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_req(rows[i].req, rows[i].typed, rows[i].res);
    end

    // random phases over several settings and idling mixes
    total = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ORIGIN_X, (ph == 7) ? 32'h7fffffff : $urandom_range(2097152) - 1048576);
      write_reg(REG_ORIGIN_Y, (ph == 7) ? 32'h80000000 : $urandom_range(2097152) - 1048576);
      write_reg(REG_CELL, (ph == 6) ? 32'h7fffffff : (ph % 3 == 0) ? 65536 :
                $urandom_range(200000, 1));
      write_reg(REG_ROW, (ph == 5) ? 32'h10000 : (ph == 4) ? 2 : $urandom_range(40, 2));
      write_reg(REG_COUNT, (ph == 3) ? 0 : (ph == 2) ? 7 : $urandom_range(4, 1));
      case (ph % 4)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
        1: begin idle_pct_in = 50; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 50; end
        default: begin idle_pct_in = 37; idle_pct_out = 37; end
      endcase
      // long receiver hold while requests keep coming
      if (ph == 1) begin
        fork
          begin
            long_hold = 1'b1;
            repeat (400) @(posedge clk);
            long_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 160; n++) begin
        // sender pauses until all responses are in
        if (ph == 2 && n == 80) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_nodes.size() != 0);
        end
        r = rand_req();
        send_req(r, 0, none);
        total++;
      end
    end

    // drain
    in_tvalid <= 1'b0;
    for (int t = 0; t < 200000 && pending_nodes.size() != 0; t++) @(posedge clk);
    repeat (100) @(posedge clk);
    mismatches += pending_nodes.size();

    $display("covered %0d random requests, %0d node responses, %0d plane writes",
             total, nodes_seen, writes_sent);
    $display("settings swept origin, cell size, row length and plane count extremes");
    if (mismatches == 0) begin
      $display("[grid_node_plane_collision_top] OK");
    end else begin
      $display("[grid_node_plane_collision_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/gnpc_pkg.sv
src/gnpc_ctrl.sv
src/gnpc_dp.sv
src/grid_node_plane_collision_top.sv
src/gnpc_checker.sv
verif/grid_node_plane_collision_top_tb.sv
